// ===== design/ritd_pkg.sv =====
package ritd_pkg;

  localparam int STEP_BITS = 8;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [3:0] DIGIT_LIMIT    = 4'd9;
  localparam logic [6:0] NUMERAL_OFFSET = 7'd48;
  localparam logic [6:0] LETTER_OFFSET  = 7'd55;

  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } div_res_t;

  function automatic logic [4:0] clamp_radix(input logic [4:0] r);
    logic [4:0] c;
    if (r < RADIX_MIN) begin
      c = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      c = RADIX_MAX;
    end else begin
      c = r;
    end
    return c;
  endfunction

  function automatic logic [6:0] digit_ascii(input logic [3:0] d);
    logic [6:0] a;
    if (d <= DIGIT_LIMIT) begin
      a = {3'b000, d} + NUMERAL_OFFSET;
    end else begin
      a = {3'b000, d} + LETTER_OFFSET;
    end
    return a;
  endfunction

endpackage

// ===== design/integer_to_radix_digits_unit.sv =====
// Each of the n digits takes one pass through the shared divider; the digit strobes
// start once all n divisions are done, and the digits then follow one per cycle.
// A new beat is accepted only in idle; busy stays high from acceptance until the
// final digit read is issued. The receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle with no strobe.
module integer_to_radix_digits_unit import ritd_pkg::*; #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [4:0]             in_radix,
  output logic                   out_valid,
  output logic [3:0]             out_digit_value,
  output logic [6:0]             out_digit_char,
  output logic                   out_last_digit
);

  localparam int AW = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t                 state_r;
  logic [4:0]             radix_r;
  logic [AW-1:0]          cnt_r;
  logic [AW-1:0]          rd_ptr_r;
  logic                   out_valid_r;
  logic                   out_last_r;

  logic                   accept;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [4:0]             div_radix;
  logic [VALUE_WIDTH-1:0] quotient;
  div_res_t               div_res;
  logic                   wr_en;
  logic                   rd_en;
  logic [3:0]             rd_data;

  assign accept       = start && (state_r == ST_IDLE);
  assign div_start    = accept || ((state_r == ST_DIV) && div_res.done && (quotient != '0));
  assign div_dividend = (state_r == ST_IDLE) ? in_value : quotient;
  assign div_radix    = (state_r == ST_IDLE) ? clamp_radix(in_radix) : radix_r;
  assign wr_en        = (state_r == ST_DIV) && div_res.done;
  assign rd_en        = (state_r == ST_EMIT);

  ritd_divider #(
    .W(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (div_radix),
    .quotient (quotient),
    .res      (div_res)
  );

  ritd_digit_buf #(
    .DEPTH(VALUE_WIDTH)
  ) u_digit_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r),
    .wr_data (div_res.rem),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            radix_r <= clamp_radix(in_radix);
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            cnt_r <= cnt_r + 1'b1;
            if (quotient == '0) begin
              rd_ptr_r <= cnt_r;
              state_r  <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (rd_ptr_r == '0);
          if (rd_ptr_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            rd_ptr_r <= rd_ptr_r - 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_last_digit  = out_last_r;
  assign out_digit_value = rd_data;
  assign out_digit_char  = digit_ascii(rd_data);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted beat did not make the unit busy.");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("Digit strobe without a preceding buffer read.");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_digit) |=> !out_valid)
    else $error("Digit strobe directly after the final digit.");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("Divider finished outside the divide phase.");

endmodule

// ===== design/ritd_divider.sv =====
module ritd_divider import ritd_pkg::*; #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [4:0]   radix,
  output logic [W-1:0] quotient,
  output div_res_t     res
);

  localparam int NSTEP = (W + STEP_BITS - 1) / STEP_BITS;
  localparam int PADW  = NSTEP * STEP_BITS;
  localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic [PADW-1:0] work_r;
  logic [3:0]      rem_r;
  logic [4:0]      radix_r;
  logic [CW-1:0]   cnt_r;
  logic            run_r;
  logic            done_r;

  logic [PADW-1:0] step_work;
  logic [3:0]      step_rem;

  // Restoring division, several quotient bits per cycle. The partial
  // remainder stays below the radix, so each step is a narrow compare.
  always_comb begin
    logic [4:0] p;
    step_work = work_r;
    step_rem  = rem_r;
    for (int i = 0; i < STEP_BITS; i++) begin
      p = {step_rem, step_work[PADW-1]};
      step_work = {step_work[PADW-2:0], 1'b0};
      if (p >= radix_r) begin
        step_rem     = 4'(p - radix_r);
        step_work[0] = 1'b1;
      end else begin
        step_rem = p[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        work_r  <= PADW'(dividend);
        rem_r   <= 4'd0;
        radix_r <= radix;
        cnt_r   <= CW'(NSTEP - 1);
        run_r   <= 1'b1;
      end else if (run_r) begin
        work_r <= step_work;
        rem_r  <= step_rem;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = work_r[W-1:0];
  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

// ===== design/ritd_digit_buf.sv =====
module ritd_digit_buf #(
  parameter int DEPTH = 31,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [3:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [3:0]    rd_data
);

  logic [3:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
